// File: src/sms_pkg.sv
// shared types and constants for the sorted multiset table
package sms_pkg;

   // request opcodes carried on req_tuser
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_DUMP   = 2'd2;

   // response status codes
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FULL      = 2'd1;
   localparam logic [1:0] STS_NOT_FOUND = 2'd2;

   // fixed field widths on the ports
   localparam int ACTION_WIDTH    = 2;
   localparam int IN_VALUE_WIDTH  = 32;
   localparam int OUT_COUNT_WIDTH = 6;
   localparam int STATUS_WIDTH    = 2;
   localparam int OUT_VALUE_WIDTH = 32;
   localparam int RSP_DATA_WIDTH  = 40;

   // command broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_SHIFT
   } cell_cmd_type;

   // per-cell compare results
   typedef struct packed {
      logic past;   // slot empty or entry >= key
      logic match;  // first entry >= key equals key
   } cell_flags_type;

endpackage

// File: src/sms_cell.sv
// one slot of the sorted chain: holds an entry and trades it with its neighbors
module sms_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                      clock,
   input  sms_pkg::cell_cmd_type     cmd,
   input  logic                      occ,
   input  logic [VALUE_WIDTH-1:0]    key,
   input  logic                      prev_past,
   input  logic [VALUE_WIDTH-1:0]    prev_value,
   input  logic [VALUE_WIDTH-1:0]    next_value,
   output logic [VALUE_WIDTH-1:0]    value,
   output sms_pkg::cell_flags_type   flags
);
   import sms_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   assign value       = value_ff;
   assign flags.past  = !occ || ($signed(value_ff) >= $signed(key));
   assign flags.match = occ && (value_ff == key) && !prev_past;

   always_comb begin
      value_in = value_ff;
      case (cmd)
         CELL_INSERT: begin
            if (flags.past && !prev_past) begin
               value_in = key;
            end else if (flags.past) begin
               value_in = prev_value;
            end
         end
         CELL_DELETE: begin
            if (flags.past) begin
               value_in = next_value;
            end
         end
         CELL_SHIFT:  value_in = next_value;
         default:     value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: src/sorted_multiset_table_top.sv
// sorted multiset table: top level with request sequencer, cell chain and response register
//
// Keeps up to DEPTH signed values in ascending order (duplicates kept) in a
// chain of cells, one entry per cell. Every request on req_ produces one or
// more responses on rsp_. For insert and delete all cells compare against the
// key in parallel and shift by one slot in the same edge, so these requests
// and the unused opcode go back to back as long as responses are taken. Dump
// shifts the chain toward cell 0 one slot per cycle, except while an entry to
// be emitted waits on a stalled response slot, and emits the last entry of
// every run of equal values; no request is taken until it ends. The table is
// empty afterwards. Insert into a full table returns status full and delete
// of an absent value returns status not found; both leave the table alone.
module sorted_multiset_table_top #(
   parameter int DEPTH       = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sms_pkg::IN_VALUE_WIDTH-1:0]   req_tdata,  // value
   input  logic [sms_pkg::ACTION_WIDTH-1:0]     req_tuser,  // action
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sms_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,  // entry_count, status, out_value
   output logic                                 rsp_tuser,  // value_valid
   output logic                                 rsp_tlast   // last
);
   import sms_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic [STATUS_WIDTH-1:0]    rsp_status_ff, rsp_status_in;
   logic [OUT_VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                       rsp_vvalid_ff, rsp_vvalid_in;
   logic                       rsp_last_ff, rsp_last_in;

   // chain wiring
   cell_cmd_type               cmd;
   logic [VALUE_WIDTH-1:0]     key;
   logic [VALUE_WIDTH-1:0]     cell_value [DEPTH];
   cell_flags_type             cell_flags [DEPTH];
   logic [DEPTH-1:0]           occ;
   logic [DEPTH-1:0]           match_vec;
   logic                       found;
   logic                       slot_free;
   logic                       req_fire;
   logic                       emit;
   logic [OUT_VALUE_WIDTH-1:0] head_value;
   logic [OUT_COUNT_WIDTH-1:0] count_out;
   logic [OUT_COUNT_WIDTH-1:0] count_plus_out;
   logic [OUT_COUNT_WIDTH-1:0] count_minus_out;
   logic [CW-1:0]              count_plus;
   logic [CW-1:0]              count_minus;

   // key from the request value, response value from cell 0
   generate
      if (VALUE_WIDTH <= IN_VALUE_WIDTH) begin : g_key_narrow
         assign key = req_tdata[VALUE_WIDTH-1:0];
      end else begin : g_key_wide
         // wide tables take the field's bits as an unsigned pattern
         assign key = {{(VALUE_WIDTH-IN_VALUE_WIDTH){1'b0}}, req_tdata};
      end
      if (VALUE_WIDTH >= OUT_VALUE_WIDTH) begin : g_out_wide
         assign head_value = cell_value[0][OUT_VALUE_WIDTH-1:0];
      end else begin : g_out_narrow
         assign head_value = {{(OUT_VALUE_WIDTH-VALUE_WIDTH){1'b0}}, cell_value[0]};
      end
   endgenerate

   // count as seen on the response field, truncated or zero-extended
   assign count_plus  = count_ff + CW'(1);
   assign count_minus = count_ff - CW'(1);
   generate
      if (CW >= OUT_COUNT_WIDTH) begin : g_cnt_trunc
         assign count_out       = count_ff[OUT_COUNT_WIDTH-1:0];
         assign count_plus_out  = count_plus[OUT_COUNT_WIDTH-1:0];
         assign count_minus_out = count_minus[OUT_COUNT_WIDTH-1:0];
      end else begin : g_cnt_ext
         assign count_out       = {{(OUT_COUNT_WIDTH-CW){1'b0}}, count_ff};
         assign count_plus_out  = {{(OUT_COUNT_WIDTH-CW){1'b0}}, count_plus};
         assign count_minus_out = {{(OUT_COUNT_WIDTH-CW){1'b0}}, count_minus};
      end
   endgenerate

   // the chain of cells; occupancy follows from the count
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic                   prev_past;
         logic [VALUE_WIDTH-1:0] prev_value;
         logic [VALUE_WIDTH-1:0] next_value;

         assign occ[gi]       = count_ff > CW'(gi);
         assign match_vec[gi] = cell_flags[gi].match;

         if (gi == 0) begin : g_head
            assign prev_past  = 1'b0;
            assign prev_value = '0;
         end else begin : g_body
            assign prev_past  = cell_flags[gi-1].past;
            assign prev_value = cell_value[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign next_value = '0;
         end else begin : g_mid
            assign next_value = cell_value[gi+1];
         end

         sms_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occ        (occ[gi]),
            .key        (key),
            .prev_past  (prev_past),
            .prev_value (prev_value),
            .next_value (next_value),
            .value      (cell_value[gi]),
            .flags      (cell_flags[gi])
         );
      end
   endgenerate

   assign found = |match_vec;

   // response slot is free when empty or being drained this cycle
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;

   // during dump cell 0 is emitted when it ends a run of equal values
   assign emit = !occ[1] || (cell_value[0] != cell_value[1]);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd           = CELL_HOLD;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_vvalid_in = rsp_vvalid_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // defaults for a single-transaction reply
               rsp_valid_in  = 1'b1;
               rsp_count_in  = count_out;
               rsp_status_in = STS_OK;
               rsp_value_in  = '0;
               rsp_vvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               unique case (req_tuser)
                  ACT_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        cmd          = CELL_INSERT;
                        count_in     = count_plus;
                        rsp_count_in = count_plus_out;
                     end
                  end
                  ACT_DELETE: begin
                     if (found) begin
                        cmd          = CELL_DELETE;
                        count_in     = count_minus;
                        rsp_count_in = count_minus_out;
                     end else begin
                        rsp_status_in = STS_NOT_FOUND;
                     end
                  end
                  ACT_DUMP: begin
                     if (count_ff != '0) begin
                        // replies come from the dump walk
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        rsp_count_in = rsp_count_ff;
                        rsp_last_in  = rsp_last_ff;
                        state_in     = ST_DUMP;
                     end else begin
                        rsp_count_in = '0;
                     end
                  end
                  default: begin
                     // unused opcode: report the count, change nothing
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (!emit || slot_free) begin
               cmd      = CELL_SHIFT;
               count_in = count_minus;
               if (count_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
               if (emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_count_in  = '0;
                  rsp_status_in = STS_OK;
                  rsp_value_in  = head_value;
                  rsp_vvalid_in = 1'b1;
                  rsp_last_in   = !occ[1];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_vvalid_ff <= rsp_vvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_value_ff, rsp_status_ff, rsp_count_ff};
   assign rsp_tuser  = rsp_vvalid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: src/sms_checker.sv
// port-level checks for the sorted multiset table, bound to the top level
module sms_port_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [sms_pkg::IN_VALUE_WIDTH-1:0] req_tdata,
   input logic [sms_pkg::ACTION_WIDTH-1:0]   req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [sms_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast
);
   import sms_pkg::*;

   logic [STATUS_WIDTH-1:0]    status;
   logic [OUT_COUNT_WIDTH-1:0] entry_count;
   logic                       req_seen;

   assign status      = rsp_tdata[OUT_COUNT_WIDTH +: STATUS_WIDTH];
   assign entry_count = rsp_tdata[OUT_COUNT_WIDTH-1:0];
   assign req_seen    = req_tvalid && req_tready && (req_tuser != '1) && (req_tdata != '0);

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a pending response is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // only dump values come without last, and dump values report an empty table
   a_dump_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (entry_count == '0) && (status == STS_OK))
      else $error("dump transaction with count or status set");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("non-dump transaction without last");

   // a request is never taken while a stalled response sits in the register
   a_no_take_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(req_seen || (req_tvalid && req_tready)))
      else $error("request taken with response slot blocked");

endmodule

bind sorted_multiset_table_top sms_port_checker u_sms_checker (.*);
